/* rtl/docking_sequence_controller_assert.svh */
// Assertion macros for the checker file of the docking sequencer.
`ifndef DOCKING_SEQUENCE_CONTROLLER_ASSERT_SVH
`define DOCKING_SEQUENCE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, muted while reset is held.
`define DSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, muted while reset is held.
`define DSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dsc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package dsc_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int TO_W        = 16;
  localparam int CMP_W       = (TIMER_WIDTH > TO_W) ? TIMER_WIDTH : TO_W;
  localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = '1;

  typedef logic [CMP_W-1:0] cmp_t;

  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_EXTENDING  = 3'd1,
    ST_SOFT       = 3'd2,
    ST_EQUALIZING = 3'd3,
    ST_HARD       = 3'd4,
    ST_RELEASING  = 3'd5
  } seq_state_t;

  typedef enum logic [6:0] {
    CMD_NOOP  = 7'd0,
    CMD_RESET = 7'd1,
    CMD_MATE  = 7'd2,
    CMD_DEMATE = 7'd3,
    CMD_HARD  = 7'd4
  } cmd_code_t;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_EXTEND  = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_ENGAGE  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ALARM_NONE    = 2'd0,
    ALARM_TIMEOUT = 2'd1,
    ALARM_LEAK    = 2'd2
  } alarm_t;

  localparam logic [1:0] LATCH_OPEN   = 2'd0;
  localparam logic [1:0] LATCH_LOCKED = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_EQUAL_TOL    = 3'd0;
  localparam logic [2:0] CFG_LEAK_THR     = 3'd1;
  localparam logic [2:0] CFG_EXTEND_TO    = 3'd2;
  localparam logic [2:0] CFG_RELEASE_TO   = 3'd3;
  localparam logic [2:0] CFG_EQUALIZE_TO  = 3'd4;
  localparam logic [2:0] CFG_SOFT_CODE    = 3'd5;
  localparam logic [2:0] CFG_RETRACT_CODE = 3'd6;

  localparam logic [14:0] EQUAL_TOL_RST    = 15'd128;
  localparam logic [14:0] LEAK_THR_RST     = 15'd384;
  localparam logic [15:0] EXTEND_TO_RST    = 16'd30;
  localparam logic [15:0] RELEASE_TO_RST   = 16'd30;
  localparam logic [15:0] EQUALIZE_TO_RST  = 16'd120;
  localparam logic [2:0]  SOFT_CODE_RST    = 3'd2;
  localparam logic [2:0]  RETRACT_CODE_RST = 3'd0;

  typedef struct packed {
    logic [14:0]     equal_tol;
    logic [14:0]     leak_thr;
    logic [TO_W-1:0] extend_to;
    logic [TO_W-1:0] release_to;
    logic [TO_W-1:0] equalize_to;
    logic [2:0]      soft_code;
    logic [2:0]      retract_code;
  } dsc_cfg_t;

  // Input item; tdata carries everything but op
  localparam int ITEM_W = 50;
  typedef struct packed {
    logic               op;
    logic [7:0]         latch;
    logic [15:0]        tunnel;
    logic signed [15:0] diff;
    logic [2:0]         collar;
    logic [6:0]         cmd;
  } dsc_item_t;

  // Result body in tdata order, lowest field last; status_valid goes in tuser
  localparam int RES_W = 77;
  typedef struct packed {
    logic [15:0]        rejected_count;
    logic [15:0]        accepted_count;
    logic signed [15:0] difference_echo;
    logic [15:0]        tunnel_echo;
    logic [2:0]         collar_echo;
    logic [1:0]         latch_status;
    logic               seal_ok;
    logic [1:0]         alarm;
    logic [1:0]         action;
    logic [2:0]         sequence_state;
  } dsc_res_body_t;

  typedef struct packed {
    logic          status_valid;
    dsc_res_body_t body;
  } dsc_res_t;

endpackage
`default_nettype wire

/* rtl/docking_sequence_controller.sv */
// Docking-collar sequencer.
// Input channel in_*: one item per handshake. in_tuser[0] says what the item
// is (0 one-second tick with collar telemetry, 1 ground command); in_tdata
// carries command code, collar code, pressure difference, tunnel pressure and
// latch count. Output channel out_*: exactly one result item per input item,
// in order. out_tuser[0] is set on tick results, which carry the status
// record; command results carry only state, action code and counters.
// Configuration: write cfg_wdata into register cfg_addr while cfg_we is high;
// write only while no item is in flight, an unused index is dropped.
// A result reaches out_* through the input register, then the result
// register. Throughput: one item per cycle while out_tready holds, set by
// the combinational state update between the two registers.
// A stalled receiver holds the result register; one further item is still
// taken into the input register, after which in_tready drops until the
// result is taken.
// Reset (synchronous, rst_n low): state idle, timer and both counters cleared,
// configuration back to its defaults, both channels empty.
`timescale 1ns / 1ps
`default_nettype none
module docking_sequence_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: command_code[6:0], collar_code[9:7], pressure_difference[25:10],
  //           tunnel_pressure[41:26], latch_count[49:42], zero pad [55:50]
  input  wire logic [55:0] in_tdata,
  // in_tuser: operation[0]
  input  wire logic [0:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: sequence_state[2:0], action[4:3], alarm[6:5], seal_ok[7],
  //   latch_status[9:8], collar_echo[12:10], tunnel_echo[28:13],
  //   difference_echo[44:29], accepted_count[60:45], rejected_count[76:61],
  //   zero pad [79:77]
  output logic [79:0]      out_tdata,
  // out_tuser: status_valid[0]
  output logic [0:0]       out_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  dsc_pkg::dsc_cfg_t  cfg_r;
  dsc_pkg::dsc_item_t item_r, item_nxt;
  dsc_pkg::dsc_res_t  res_r, res_nxt;
  logic in_valid_r, out_valid_r;
  logic advance, in_take, step_en;

  // Move the result stage whenever its register is empty or being taken
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign in_take   = in_tvalid && in_tready;
  assign step_en   = in_valid_r && advance;

  always_comb begin
    item_nxt.op     = in_tuser[0];
    item_nxt.cmd    = in_tdata[6:0];
    item_nxt.collar = in_tdata[9:7];
    item_nxt.diff   = $signed(in_tdata[25:10]);
    item_nxt.tunnel = in_tdata[41:26];
    item_nxt.latch  = in_tdata[49:42];
  end

  // Configuration registers: tolerance, threshold and code registers keep only their low bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.equal_tol    <= dsc_pkg::EQUAL_TOL_RST;
      cfg_r.leak_thr     <= dsc_pkg::LEAK_THR_RST;
      cfg_r.extend_to    <= dsc_pkg::EXTEND_TO_RST;
      cfg_r.release_to   <= dsc_pkg::RELEASE_TO_RST;
      cfg_r.equalize_to  <= dsc_pkg::EQUALIZE_TO_RST;
      cfg_r.soft_code    <= dsc_pkg::SOFT_CODE_RST;
      cfg_r.retract_code <= dsc_pkg::RETRACT_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        dsc_pkg::CFG_EQUAL_TOL:    cfg_r.equal_tol    <= cfg_wdata[14:0];
        dsc_pkg::CFG_LEAK_THR:     cfg_r.leak_thr     <= cfg_wdata[14:0];
        dsc_pkg::CFG_EXTEND_TO:    cfg_r.extend_to    <= cfg_wdata;
        dsc_pkg::CFG_RELEASE_TO:   cfg_r.release_to   <= cfg_wdata;
        dsc_pkg::CFG_EQUALIZE_TO:  cfg_r.equalize_to  <= cfg_wdata;
        dsc_pkg::CFG_SOFT_CODE:    cfg_r.soft_code    <= cfg_wdata[2:0];
        dsc_pkg::CFG_RETRACT_CODE: cfg_r.retract_code <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // Handshake state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) out_valid_r <= in_valid_r;
    end
  end

  // Payload registers: hold the input item, capture the result on a step
  always_ff @(posedge clk) begin
    if (in_take) item_r <= item_nxt;
    if (step_en) res_r <= res_nxt;
  end

  dsc_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .cfg     (cfg_r),
    .item    (item_r),
    .result  (res_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.status_valid;
  assign out_tdata  = {3'b000, res_r.body};

endmodule
`default_nettype wire

/* rtl/dsc_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
module dsc_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire dsc_pkg::dsc_cfg_t  cfg,
  input  wire dsc_pkg::dsc_item_t item,
  output dsc_pkg::dsc_res_t       result
);

  dsc_pkg::seq_state_t state_r, state_nxt;
  logic [dsc_pkg::TIMER_WIDTH-1:0] timer_r, timer_nxt, timer_inc;
  logic [15:0] acc_r, acc_nxt, rej_r, rej_nxt;

  logic is_tick, seal, leak, ext_to, rel_to, eq_to, at_soft, at_retract;
  dsc_pkg::action_t action;
  dsc_pkg::alarm_t  alarm;

  assign is_tick    = !item.op;
  assign timer_inc  = (timer_r == dsc_pkg::TIMER_MAX) ? timer_r : timer_r + 1'b1;
  assign seal       = item.diff < $signed({1'b0, cfg.equal_tol});
  assign leak       = item.diff > $signed({1'b0, cfg.leak_thr});
  assign ext_to     = dsc_pkg::cmp_t'(timer_inc) > dsc_pkg::cmp_t'(cfg.extend_to);
  assign rel_to     = dsc_pkg::cmp_t'(timer_inc) > dsc_pkg::cmp_t'(cfg.release_to);
  assign eq_to      = dsc_pkg::cmp_t'(timer_inc) > dsc_pkg::cmp_t'(cfg.equalize_to);
  assign at_soft    = item.collar == cfg.soft_code;
  assign at_retract = item.collar == cfg.retract_code;

  // Next state, timer and counters
  always_comb begin
    state_nxt = state_r;
    timer_nxt = timer_r;
    acc_nxt   = acc_r;
    rej_nxt   = rej_r;
    if (is_tick) begin
      timer_nxt = timer_inc;
      case (state_r)
        dsc_pkg::ST_EXTENDING: begin
          if (at_soft || ext_to) begin
            state_nxt = dsc_pkg::ST_SOFT;
            timer_nxt = '0;
          end
        end
        dsc_pkg::ST_EQUALIZING: begin
          if (seal) begin
            state_nxt = dsc_pkg::ST_HARD;
            timer_nxt = '0;
          end
        end
        dsc_pkg::ST_RELEASING: begin
          if (at_retract || rel_to) begin
            state_nxt = dsc_pkg::ST_IDLE;
            timer_nxt = '0;
          end
        end
        default: ;
      endcase
    end else begin
      case (item.cmd)
        dsc_pkg::CMD_NOOP: acc_nxt = acc_r + 1'b1;
        dsc_pkg::CMD_RESET: begin
          acc_nxt = '0;
          rej_nxt = '0;
        end
        dsc_pkg::CMD_MATE: begin
          if (state_r == dsc_pkg::ST_IDLE) begin
            state_nxt = dsc_pkg::ST_EXTENDING;
            timer_nxt = '0;
            acc_nxt   = acc_r + 1'b1;
          end else begin
            rej_nxt = rej_r + 1'b1;
          end
        end
        dsc_pkg::CMD_DEMATE: begin
          if (state_r == dsc_pkg::ST_SOFT || state_r == dsc_pkg::ST_HARD) begin
            state_nxt = dsc_pkg::ST_RELEASING;
            timer_nxt = '0;
            acc_nxt   = acc_r + 1'b1;
          end else begin
            rej_nxt = rej_r + 1'b1;
          end
        end
        dsc_pkg::CMD_HARD: begin
          if (state_r == dsc_pkg::ST_SOFT) begin
            state_nxt = dsc_pkg::ST_EQUALIZING;
            timer_nxt = '0;
            acc_nxt   = acc_r + 1'b1;
          end else begin
            rej_nxt = rej_r + 1'b1;
          end
        end
        default: rej_nxt = rej_r + 1'b1;
      endcase
    end
  end

  // Action and alarm codes
  always_comb begin
    action = dsc_pkg::ACT_NONE;
    alarm  = dsc_pkg::ALARM_NONE;
    if (is_tick) begin
      case (state_r)
        dsc_pkg::ST_EQUALIZING: begin
          if (seal) action = dsc_pkg::ACT_ENGAGE;
          else if (eq_to) alarm = dsc_pkg::ALARM_TIMEOUT;
        end
        dsc_pkg::ST_HARD: begin
          if (leak) alarm = dsc_pkg::ALARM_LEAK;
        end
        default: ;
      endcase
    end else begin
      case (item.cmd)
        dsc_pkg::CMD_MATE: begin
          if (state_r == dsc_pkg::ST_IDLE) action = dsc_pkg::ACT_EXTEND;
        end
        dsc_pkg::CMD_DEMATE: begin
          if (state_r == dsc_pkg::ST_SOFT || state_r == dsc_pkg::ST_HARD)
            action = dsc_pkg::ACT_RELEASE;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result                      = '0;
    result.status_valid         = is_tick;
    result.body.sequence_state  = state_nxt;
    result.body.action          = action;
    result.body.alarm           = alarm;
    result.body.accepted_count  = acc_nxt;
    result.body.rejected_count  = rej_nxt;
    if (is_tick) begin
      result.body.seal_ok         = seal;
      result.body.latch_status    = (item.latch != '0) ? dsc_pkg::LATCH_LOCKED
                                                       : dsc_pkg::LATCH_OPEN;
      result.body.collar_echo     = item.collar;
      result.body.tunnel_echo     = item.tunnel;
      result.body.difference_echo = item.diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dsc_pkg::ST_IDLE;
      timer_r <= '0;
      acc_r   <= '0;
      rej_r   <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
      timer_r <= timer_nxt;
      acc_r   <= acc_nxt;
      rej_r   <= rej_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/dsc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "docking_sequence_controller_assert.svh"
module dsc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic [79:0] out_tdata,
  input wire logic [0:0]  out_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready
);

  dsc_pkg::dsc_res_body_t res;
  logic tick;

  assign res  = out_tdata[dsc_pkg::RES_W-1:0];
  assign tick = out_tuser[0];

  // A stalled result holds still
  `DSC_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // Command results carry no telemetry or alarm
  `DSC_ASSERT_IMPLY(a_cmd_clean, clk, rst_n, out_tvalid && !tick, res.alarm == dsc_pkg::ALARM_NONE && !res.seal_ok && res.latch_status == dsc_pkg::LATCH_OPEN && res.collar_echo == '0 && res.tunnel_echo == '0 && res.difference_echo == '0, "command result carries status fields")

  // Hard latch is engaged only on the tick that completes equalization
  `DSC_ASSERT_IMPLY(a_engage_hard, clk, rst_n, out_tvalid && res.action == dsc_pkg::ACT_ENGAGE, tick && res.sequence_state == dsc_pkg::ST_HARD && res.seal_ok, "engage without equalized seal")

  // Alarms belong to the state that raises them
  `DSC_ASSERT_IMPLY(a_alarm_state, clk, rst_n, out_tvalid && res.alarm != dsc_pkg::ALARM_NONE, tick && ((res.alarm == dsc_pkg::ALARM_TIMEOUT && res.sequence_state == dsc_pkg::ST_EQUALIZING) || (res.alarm == dsc_pkg::ALARM_LEAK && res.sequence_state == dsc_pkg::ST_HARD)), "alarm in wrong state")

endmodule

bind docking_sequence_controller dsc_checker u_dsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
`default_nettype wire
